[sv/msps_pkg.sv]
// shared widths, action codes and timing constants for the servo pulse sequencer
package msps_pkg;

    localparam int unsigned NUM_CHANNELS_DEF = 4;

    localparam int unsigned CHANNEL_W  = 2;
    localparam int unsigned POSITION_W = 8;
    localparam int unsigned DRIVE_W    = 4;
    localparam int unsigned COMPARE_W  = 16;

    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_EVENT = 1'b1;

    localparam logic [POSITION_W-1:0] POS_LIMIT   = 8'd250;
    localparam int unsigned           POS_SHIFT   = 3;
    localparam logic [COMPARE_W-1:0]  HIGH_BASE   = 16'd2000;
    localparam logic [COMPARE_W-1:0]  FRAME_TICKS = 16'd5000;

endpackage

[sv/msps_in_if.sv]
// input channel: position writes and compare-match events
interface msps_in_if;
    import msps_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [CHANNEL_W-1:0]  channel;
    logic [POSITION_W-1:0] position;

    modport source (output valid, output action, output channel, output position,
                    input ready);
    modport sink   (input valid, input action, input channel, input position,
                    output ready);
endinterface

[sv/msps_out_if.sv]
// output channel: pulse drive pattern and next compare time
interface msps_out_if;
    import msps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DRIVE_W-1:0]   channel_drive;
    logic [COMPARE_W-1:0] next_compare;
    logic                 pulse_phase;

    modport source (output valid, output channel_drive, output next_compare,
                    output pulse_phase, input ready);
    modport sink   (input valid, input channel_drive, input next_compare,
                    input pulse_phase, output ready);
endinterface

[sv/multiplexed_servo_pulse_sequencer_unit.sv]
// top level of the time-multiplexed servo pulse sequencer
// Each input beat is either a position write (action 0), which clamps the code to 250 and
// stores it for the channel, or a compare-match event (action 1), which alternates between a
// high pulse on the next channel (one-hot drive, 2000 + 8*position ticks) and a low gap
// (all zero, 5000 minus the high time) and returns the new 16-bit compare time. A write gives
// no result beat; an event gives exactly one. Every beat passes an input register and, for an
// event, a result register, so one beat is taken every cycle unless an event waits in the input
// register for an earlier result not yet taken; an event's result is valid once it has passed
// both registers in that order. The result register lets the next beat enter while a result
// waits. Positions reset to code 0 and the first event starts a high pulse on channel 1.
module multiplexed_servo_pulse_sequencer_unit #(
    parameter int unsigned NUM_CHANNELS = msps_pkg::NUM_CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    msps_in_if.sink     item,
    msps_out_if.source  result
);
    import msps_pkg::*;

    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_action_reg;
    logic [CHANNEL_W-1:0]  s1_channel_reg;
    logic [POSITION_W-1:0] s1_position_reg;

    logic [POSITION_W-1:0] position_reg  [NUM_CHANNELS];
    logic [POSITION_W-1:0] position_next [NUM_CHANNELS];
    logic [IDX_W-1:0]      active_reg, active_next;
    logic                  high_reg, high_next;
    logic [COMPARE_W-1:0]  compare_reg, compare_next;

    logic                  out_valid_reg, out_valid_next;
    logic [DRIVE_W-1:0]    drive_reg, drive_next;
    logic                  phase_reg, phase_next;

    logic                  s1_fire;
    logic                  s1_event;
    logic [IDX_W-1:0]      step_idx;
    logic [IDX_W-1:0]      rd_idx;
    logic [IDX_W-1:0]      wr_idx;
    logic [POSITION_W-1:0] pos_clamped;
    logic [COMPARE_W-1:0]  high_ticks;
    logic [COMPARE_W-1:0]  duration;

    assign s1_event = s1_action_reg == ACTION_EVENT;
    assign s1_fire  = s1_valid_reg && (!s1_event || !out_valid_reg || result.ready);

    assign item.ready = !s1_valid_reg || s1_fire;

    assign step_idx    = (active_reg == LAST_IDX) ? '0 : active_reg + IDX_W'(1);
    assign rd_idx      = high_reg ? active_reg : step_idx;
    assign wr_idx      = IDX_W'(s1_channel_reg);
    assign pos_clamped = (s1_position_reg > POS_LIMIT) ? POS_LIMIT : s1_position_reg;
    assign high_ticks  = HIGH_BASE
                         + {{(COMPARE_W-POSITION_W-POS_SHIFT){1'b0}}, position_reg[rd_idx],
                            {POS_SHIFT{1'b0}}};
    assign duration    = high_reg ? FRAME_TICKS - high_ticks : high_ticks;

    always_comb
    begin
        s1_valid_next  = item.ready ? item.valid : s1_valid_reg;
        position_next  = position_reg;
        active_next    = active_reg;
        high_next      = high_reg;
        compare_next   = compare_reg;
        out_valid_next = out_valid_reg && !result.ready;
        drive_next     = drive_reg;
        phase_next     = phase_reg;

        if (s1_fire)
        begin
            if (!s1_event)
            begin
                if (int'(s1_channel_reg) < NUM_CHANNELS)
                begin
                    position_next[wr_idx] = pos_clamped;
                end
            end
            else
            begin
                out_valid_next = 1'b1;
                compare_next   = compare_reg + duration;
                high_next      = !high_reg;
                if (high_reg)
                begin
                    drive_next = '0;
                    phase_next = 1'b0;
                end
                else
                begin
                    active_next = step_idx;
                    drive_next  = (int'(step_idx) < DRIVE_W)
                                  ? DRIVE_W'(1) << step_idx : '0;
                    phase_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                position_reg[i] <= '0;
            end
            active_reg    <= '0;
            high_reg      <= 1'b0;
            compare_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            position_reg  <= position_next;
            active_reg    <= active_next;
            high_reg      <= high_next;
            compare_reg   <= compare_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_action_reg   <= item.action;
            s1_channel_reg  <= item.channel;
            s1_position_reg <= item.position;
        end
        drive_reg <= drive_next;
        phase_reg <= phase_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.channel_drive = drive_reg;
    assign result.next_compare  = compare_reg;
    assign result.pulse_phase   = phase_reg;

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the multiplexed servo pulse sequencer
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import msps_pkg::*;

    localparam int unsigned NUM_CH = NUM_CHANNELS_DEF;

    typedef struct packed {
        logic                  drain_first;
        logic                  action;
        logic [CHANNEL_W-1:0]  channel;
        logic [POSITION_W-1:0] position;
    } servo_cmd_t;

    typedef struct packed {
        logic [DRIVE_W-1:0]   drive;
        logic [COMPARE_W-1:0] compare;
        logic                 phase;
    } pulse_edge_t;

    logic clk;
    logic rst_n;

    msps_in_if  cmd_bus ();
    msps_out_if edge_bus ();

    multiplexed_servo_pulse_sequencer_unit #(
        .NUM_CHANNELS(NUM_CH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(cmd_bus),
        .result(edge_bus)
    );

    servo_cmd_t  cmd_q[$];
    pulse_edge_t pulse_q[$];

    logic [POSITION_W-1:0] pos_table[NUM_CH];
    logic [CHANNEL_W-1:0]  active_ch;
    logic                  high_phase;
    logic [COMPARE_W-1:0]  cmp_time;

    int unsigned beats_sent;
    int unsigned edges_seen;
    int unsigned mismatches;

    function automatic logic [COMPARE_W-1:0] high_ticks(input logic [CHANNEL_W-1:0] ch);
        return HIGH_BASE + (COMPARE_W'(pos_table[ch]) << POS_SHIFT);
    endfunction

    task automatic step_sequencer(input servo_cmd_t c);
        logic [COMPARE_W-1:0] span;
        pulse_edge_t          e;
        if (c.action == ACTION_WRITE)
        begin
            pos_table[c.channel] = (c.position > POS_LIMIT) ? POS_LIMIT : c.position;
        end
        else
        begin
            if (high_phase)
            begin
                span = FRAME_TICKS - high_ticks(active_ch);
                e.drive = '0;
                e.phase = 1'b0;
                high_phase = 1'b0;
            end
            else
            begin
                if (int'(active_ch) == NUM_CH - 1)
                    active_ch = '0;
                else
                    active_ch = active_ch + 2'd1;
                e.drive = DRIVE_W'(1) << active_ch;
                span = high_ticks(active_ch);
                e.phase = 1'b1;
                high_phase = 1'b1;
            end
            cmp_time = cmp_time + span;
            e.compare = cmp_time;
            pulse_q.push_back(e);
        end
    endtask

    task automatic queue_cmd(input logic drain, input logic act,
                             input int unsigned ch, input int unsigned pos);
        servo_cmd_t c;
        c.drain_first = drain;
        c.action = act;
        c.channel = CHANNEL_W'(ch);
        c.position = POSITION_W'(pos);
        cmd_q.push_back(c);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.action <= ACTION_WRITE;
            cmd_bus.channel <= '0;
            cmd_bus.position <= '0;
            beats_sent <= 0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                servo_cmd_t acc;
                acc.drain_first = 1'b0;
                acc.action = cmd_bus.action;
                acc.channel = cmd_bus.channel;
                acc.position = cmd_bus.position;
                step_sequencer(acc);
            end
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (cmd_q.size() != 0
                    && !(cmd_q[0].drain_first && pulse_q.size() != 0)
                    && ((beats_sent >= 300 && beats_sent < 520)
                        || $urandom_range(0, 99) >= 14))
                begin
                    servo_cmd_t nxt;
                    nxt = cmd_q.pop_front();
                    cmd_bus.valid <= 1'b1;
                    cmd_bus.action <= nxt.action;
                    cmd_bus.channel <= nxt.channel;
                    cmd_bus.position <= nxt.position;
                    beats_sent <= beats_sent + 1;
                end
                else
                begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_bus.ready <= 1'b0;
            edges_seen <= 0;
        end
        else
        begin
            if (edge_bus.valid && edge_bus.ready)
            begin
                edges_seen <= edges_seen + 1;
                if (pulse_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: drive %h compare %h phase %b",
                                 edge_bus.channel_drive, edge_bus.next_compare,
                                 edge_bus.pulse_phase);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    pulse_edge_t want;
                    want = pulse_q.pop_front();
                    if (edge_bus.channel_drive !== want.drive
                        || edge_bus.next_compare !== want.compare
                        || edge_bus.pulse_phase !== want.phase)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: drive %h/%h compare %h/%h phase %b/%b",
                                     want.drive, edge_bus.channel_drive,
                                     want.compare, edge_bus.next_compare,
                                     want.phase, edge_bus.pulse_phase);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            edge_bus.ready <= (edges_seen >= 150 && edges_seen < 300)
                              || ($urandom_range(0, 99) >= 14);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.action = ACTION_WRITE;
        cmd_bus.channel = '0;
        cmd_bus.position = '0;
        edge_bus.ready = 1'b0;
        mismatches = 0;
        for (int i = 0; i < NUM_CH; i++)
            pos_table[i] = '0;
        active_ch = '0;
        high_phase = 1'b0;
        cmp_time = '0;

        // reset positions, then clamping and every channel in turn
        queue_cmd(1'b0, ACTION_EVENT, 0, 0);
        queue_cmd(1'b0, ACTION_EVENT, 3, 255);
        queue_cmd(1'b0, ACTION_WRITE, 0, 255);
        queue_cmd(1'b0, ACTION_WRITE, 1, 0);
        queue_cmd(1'b0, ACTION_WRITE, 2, 250);
        queue_cmd(1'b0, ACTION_WRITE, 3, 251);
        queue_cmd(1'b0, ACTION_EVENT, 0, 0);
        // position rewritten while its pulse is high
        queue_cmd(1'b0, ACTION_WRITE, 2, 0);
        queue_cmd(1'b0, ACTION_EVENT, 0, 0);
        queue_cmd(1'b0, ACTION_EVENT, 0, 0);
        queue_cmd(1'b0, ACTION_EVENT, 0, 0);
        queue_cmd(1'b0, ACTION_EVENT, 0, 0);
        queue_cmd(1'b0, ACTION_EVENT, 0, 0);
        queue_cmd(1'b0, ACTION_EVENT, 0, 0);
        queue_cmd(1'b0, ACTION_EVENT, 0, 0);
        queue_cmd(1'b0, ACTION_WRITE, 3, 170);
        queue_cmd(1'b0, ACTION_WRITE, 0, 85);
        queue_cmd(1'b0, ACTION_WRITE, 1, 249);
        for (int i = 0; i < 6; i++)
            queue_cmd(1'b0, ACTION_EVENT, 1, 0);

        for (int i = 0; i < 1030; i++)
        begin
            int unsigned pos;
            pos = ($urandom_range(0, 4) == 0) ? $urandom_range(245, 255)
                                              : $urandom_range(0, 255);
            queue_cmd((i == 400 || i == 800),
                      ($urandom_range(0, 99) < 60) ? ACTION_EVENT : ACTION_WRITE,
                      $urandom_range(0, 3), pos);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (cmd_q.size() != 0 || cmd_bus.valid)
            @(negedge clk);
        while (pulse_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (mismatches == 0 && pulse_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
